// ===== hw/rtl/sorted_table_binary_lookup_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted table lookup assertion macros
// Shared concurrent assertion wrappers for the sorted table lookup unit.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_LOOKUP_UNIT_DEFINES_SVH
`define SORTED_TABLE_BINARY_LOOKUP_UNIT_DEFINES_SVH

// check a property on every clock edge outside reset
`define STBL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define STBL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/stbl_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table lookup package
// Field widths, opcodes and sequencer states of the sorted table lookup unit.
// ----------------------------------------------------------------------------
package stbl_pkg;

  localparam int unsigned CNT_W    = 11;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned KEY_W    = 64;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHECK
  } state_e;

endpackage

// ===== hw/rtl/sorted_table_binary_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary lookup unit
// Table of address/handle entries with a lower-bound binary search lookup.
// ----------------------------------------------------------------------------
// A load transaction writes one table entry; an index at or beyond
// TABLE_DEPTH is dropped. A lookup transaction searches the first
// entry_count entries (saturated to TABLE_DEPTH) and returns found plus the
// handle of the lowest entry equal to the key, or found 0 and handle 0. The
// input is stalled from the cycle after a lookup is taken until it is done.
// The search runs in the address memory read loop, which probes one
// midpoint per cycle, and ends in a final compare step that waits while the
// output is stalled. The result sits in an output register, so a new
// transaction is taken while it waits. The table needs no clearing after
// reset; entries must be loaded before they are searched.
`include "sorted_table_binary_lookup_unit_defines.svh"

module sorted_table_binary_lookup_unit #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [stbl_pkg::CNT_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            opcode_i,
  input  logic [stbl_pkg::IDX_W-1:0]      entry_index_i,
  input  logic [stbl_pkg::ADDR_W-1:0]     entry_address_i,
  input  logic [stbl_pkg::HANDLE_W-1:0]   entry_handle_i,
  input  logic [stbl_pkg::KEY_W-1:0]      lookup_key_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            found_o,
  output logic [stbl_pkg::HANDLE_W-1:0]   target_handle_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LW = (CW > stbl_pkg::CNT_W) ? CW : stbl_pkg::CNT_W;
  localparam int unsigned IW = (CW > stbl_pkg::IDX_W) ? CW : stbl_pkg::IDX_W;

  logic [stbl_pkg::ADDR_W-1:0]   addr_mem [TABLE_DEPTH];
  logic [stbl_pkg::HANDLE_W-1:0] handle_mem [TABLE_DEPTH];

  stbl_pkg::state_e state_q, state_d;

  logic [stbl_pkg::CNT_W-1:0]    count_q;
  logic [CW-1:0]                 lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, limit_q, limit_d;
  logic [stbl_pkg::ADDR_W-1:0]   key_lo_q, key_lo_d;
  logic                          key_hi_q, key_hi_d;
  logic [stbl_pkg::ADDR_W-1:0]   rd_addr_q;
  logic [stbl_pkg::HANDLE_W-1:0] rd_handle_q;
  logic                          out_valid_q, out_valid_d;
  logic                          found_q, found_d;
  logic [stbl_pkg::HANDLE_W-1:0] handle_q, handle_d;

  logic                          in_accept;
  logic                          is_lookup;
  logic [IW-1:0]                 idx_ext;
  logic                          wr_en;
  logic                          rd_en;
  logic [AW-1:0]                 rd_idx;
  logic [CW-1:0]                 limit_now;
  logic [CW-1:0]                 base_lo, base_hi, step_mid;
  logic                          step_more;
  logic                          probe_less;
  logic                          check_hit;
  logic                          out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != stbl_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign is_lookup   = (opcode_i == stbl_pkg::OP_LOOKUP);
  assign idx_ext     = IW'(entry_index_i);
  assign wr_en       = in_accept && !is_lookup && (idx_ext < IW'(TABLE_DEPTH));
  assign out_free    = !out_valid_q || !out_stall_i;

  assign limit_now = (LW'(count_q) > LW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_q);

  assign probe_less = key_hi_q || (rd_addr_q < key_lo_q);
  assign check_hit  = (lo_q < limit_q) && !key_hi_q && (rd_addr_q == key_lo_q);

  always_comb begin
    if (state_q == stbl_pkg::ST_PROBE) begin
      if (probe_less) begin
        base_lo = mid_q + CW'(1);
        base_hi = hi_q;
      end else begin
        base_lo = lo_q;
        base_hi = mid_q;
      end
    end else begin
      base_lo = '0;
      base_hi = limit_now;
    end
    step_more = (base_lo < base_hi);
    step_mid  = base_lo + ((base_hi - base_lo) >> 1);
    rd_idx    = step_more ? step_mid[AW-1:0] : base_lo[AW-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stbl_pkg::ST_IDLE: begin
        if (in_accept && is_lookup) begin
          state_d = step_more ? stbl_pkg::ST_PROBE : stbl_pkg::ST_CHECK;
        end
      end
      stbl_pkg::ST_PROBE: begin
        state_d = step_more ? stbl_pkg::ST_PROBE : stbl_pkg::ST_CHECK;
      end
      stbl_pkg::ST_CHECK: begin
        if (out_free) begin
          state_d = stbl_pkg::ST_IDLE;
        end
      end
      default: state_d = stbl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en       = 1'b0;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    limit_d     = limit_q;
    key_lo_d    = key_lo_q;
    key_hi_d    = key_hi_q;
    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    handle_d    = handle_q;
    unique case (state_q)
      stbl_pkg::ST_IDLE: begin
        if (in_accept && is_lookup) begin
          rd_en    = 1'b1;
          lo_d     = base_lo;
          hi_d     = base_hi;
          mid_d    = step_mid;
          limit_d  = limit_now;
          key_lo_d = lookup_key_i[stbl_pkg::ADDR_W-1:0];
          key_hi_d = |lookup_key_i[stbl_pkg::KEY_W-1:stbl_pkg::ADDR_W];
        end
      end
      stbl_pkg::ST_PROBE: begin
        rd_en = 1'b1;
        lo_d  = base_lo;
        hi_d  = base_hi;
        mid_d = step_mid;
      end
      stbl_pkg::ST_CHECK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          found_d     = check_hit;
          handle_d    = check_hit ? rd_handle_q : '0;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stbl_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    limit_q  <= limit_d;
    key_lo_q <= key_lo_d;
    key_hi_q <= key_hi_d;
    found_q  <= found_d;
    handle_q <= handle_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      addr_mem[idx_ext[AW-1:0]]   <= entry_address_i;
      handle_mem[idx_ext[AW-1:0]] <= entry_handle_i;
    end
    if (rd_en) begin
      rd_addr_q   <= addr_mem[rd_idx];
      rd_handle_q <= handle_mem[rd_idx];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign target_handle_o = handle_q;

  `STBL_ASSERT(a_probe_mid_in_range, (state_q == stbl_pkg::ST_PROBE) |-> ((mid_q >= lo_q) && (mid_q < hi_q)), "probe midpoint outside search window")
  `STBL_ASSERT(a_window_within_limit, (state_q != stbl_pkg::ST_IDLE) |-> ((lo_q <= hi_q) && (hi_q <= limit_q)), "search window exceeds entry limit")
  `STBL_ASSERT(a_lookup_starts, (in_valid_i && !in_stall_o && (opcode_i == stbl_pkg::OP_LOOKUP)) |=> (state_q != stbl_pkg::ST_IDLE), "accepted lookup did not start a search")
  `STBL_ASSERT(a_check_delivers, ((state_q == stbl_pkg::ST_CHECK) && (state_d == stbl_pkg::ST_IDLE)) |=> out_valid_o, "finished lookup left no result")
  `STBL_ASSERT(a_miss_zero_handle, (out_valid_o && !found_o) |-> (target_handle_o == '0), "miss result carries a nonzero handle")
  `STBL_ASSERT_ALWAYS(a_reset_idle, (!rst_ni) |=> (!out_valid_o && !in_stall_o), "block not idle after reset")

endmodule

// ===== dv/sorted_table_binary_lookup_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table lookup checker
// Watches the config, input and result channels of the lookup unit. Keeps its
// own copy of the table and entry count, works out the lower-bound search
// answer for every accepted lookup, and compares each accepted result in
// order against the oldest answer still due.
// ----------------------------------------------------------------------------
module sorted_table_binary_lookup_unit_checker #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [stbl_pkg::CNT_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          opcode_i,
  input  logic [stbl_pkg::IDX_W-1:0]    entry_index_i,
  input  logic [stbl_pkg::ADDR_W-1:0]   entry_address_i,
  input  logic [stbl_pkg::HANDLE_W-1:0] entry_handle_i,
  input  logic [stbl_pkg::KEY_W-1:0]    lookup_key_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          found_i,
  input  logic [stbl_pkg::HANDLE_W-1:0] target_handle_i,
  output int                            mismatch_count_o,
  output int                            answers_pending_o
);

  typedef struct packed {
    logic                          found;
    logic [stbl_pkg::HANDLE_W-1:0] handle;
  } lookup_answer_t;

  logic [stbl_pkg::ADDR_W-1:0]   addr_copy   [TABLE_DEPTH];
  logic [stbl_pkg::HANDLE_W-1:0] handle_copy [TABLE_DEPTH];
  logic [stbl_pkg::CNT_W-1:0]    count_copy;
  lookup_answer_t                answers_due [$];

  function automatic lookup_answer_t search_table(input logic [stbl_pkg::KEY_W-1:0] key);
    int unsigned                span;
    int unsigned                lo;
    int unsigned                hi;
    int unsigned                mid;
    logic [stbl_pkg::KEY_W-1:0] probe;
    lookup_answer_t             ans;
    span = (count_copy > TABLE_DEPTH) ? TABLE_DEPTH : count_copy;
    lo = 0;
    hi = span;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      probe = {32'h0, addr_copy[mid]};
      if (probe < key) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    ans.found = 1'b0;
    ans.handle = '0;
    if (lo < span) begin
      probe = {32'h0, addr_copy[lo]};
      if (probe == key) begin
        ans.found = 1'b1;
        ans.handle = handle_copy[lo];
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_answer_t due;
    if (!rst_ni) begin
      answers_due.delete();
      count_copy = '0;
      mismatch_count_o = 0;
      answers_pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10) begin
            $display("%0t: result transaction with none due: found=%0b handle=%h",
                     $realtime, found_i, target_handle_i);
          end
        end else begin
          due = answers_due.pop_front();
          if (found_i !== due.found || target_handle_i !== due.handle) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("%0t: lookup mismatch: expected found=%0b handle=%h, got found=%0b handle=%h",
                       $realtime, due.found, due.handle, found_i, target_handle_i);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        count_copy = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        if (opcode_i == stbl_pkg::OP_LOOKUP) begin
          answers_due.push_back(search_table(lookup_key_i));
        end else if (entry_index_i < TABLE_DEPTH) begin
          addr_copy[entry_index_i] = entry_address_i;
          handle_copy[entry_index_i] = entry_handle_i;
        end
      end
      answers_pending_o = answers_due.size();
    end
  end

endmodule

// ===== dv/sorted_table_binary_lookup_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table lookup testbench
// Loads sorted, duplicate-laden and unsorted tables, sets the entry count to
// values from empty to beyond the table depth, and fires lookups that hit,
// just miss, or carry keys wider than 32 bits. Random idle bursts on both
// channels; a checker predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module sorted_table_binary_lookup_unit_tb;

  localparam int unsigned TABLE_DEPTH  = 1024;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned ITEM_TARGET  = 1430;
  localparam int unsigned CALM_AFTER   = 1250;

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          cfg_valid_i     = 1'b0;
  logic [stbl_pkg::CNT_W-1:0]    cfg_wdata_i     = '0;
  logic                          in_valid_i      = 1'b0;
  logic                          opcode_i        = stbl_pkg::OP_LOAD;
  logic [stbl_pkg::IDX_W-1:0]    entry_index_i   = '0;
  logic [stbl_pkg::ADDR_W-1:0]   entry_address_i = '0;
  logic [stbl_pkg::HANDLE_W-1:0] entry_handle_i  = '0;
  logic [stbl_pkg::KEY_W-1:0]    lookup_key_i    = '0;
  logic                          out_stall_i     = 1'b0;
  logic                          cfg_ready_o;
  logic                          in_stall_o;
  logic                          out_valid_o;
  logic                          found_o;
  logic [stbl_pkg::HANDLE_W-1:0] target_handle_o;

  int                            mismatches;
  int                            pending;
  int unsigned                   items_sent   = 0;
  bit                            calm         = 1'b0;
  bit                            hush         = 1'b0;
  int                            stall_left;
  logic [stbl_pkg::ADDR_W-1:0]   shadow_addr [TABLE_DEPTH];
  bit                            shadow_set  [TABLE_DEPTH];
  int unsigned                   ready_prefix = 0;

  always #10 clk_i = ~clk_i;

  sorted_table_binary_lookup_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .entry_index_i  (entry_index_i),
    .entry_address_i(entry_address_i),
    .entry_handle_i (entry_handle_i),
    .lookup_key_i   (lookup_key_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .target_handle_o(target_handle_o)
  );

  sorted_table_binary_lookup_unit_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) checker_u (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .opcode_i         (opcode_i),
    .entry_index_i    (entry_index_i),
    .entry_address_i  (entry_address_i),
    .entry_handle_i   (entry_handle_i),
    .lookup_key_i     (lookup_key_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .found_i          (found_o),
    .target_handle_i  (target_handle_o),
    .mismatch_count_o (mismatches),
    .answers_pending_o(pending)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (calm || hush) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(1, 3);
      out_stall_i <= 1'b1;
    end
  end

  task automatic send_item(input logic op, input logic [stbl_pkg::IDX_W-1:0] idx,
                           input logic [stbl_pkg::ADDR_W-1:0] addr,
                           input logic [stbl_pkg::HANDLE_W-1:0] hnd,
                           input logic [stbl_pkg::KEY_W-1:0] key);
    if (!calm && !hush && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    entry_index_i <= idx;
    entry_address_i <= addr;
    entry_handle_i <= hnd;
    lookup_key_i <= key;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic load_entry(input int unsigned idx, input logic [stbl_pkg::ADDR_W-1:0] addr,
                            input logic [stbl_pkg::HANDLE_W-1:0] hnd);
    send_item(stbl_pkg::OP_LOAD, idx[stbl_pkg::IDX_W-1:0], addr, hnd, {$urandom, $urandom});
    shadow_addr[idx] = addr;
    shadow_set[idx] = 1'b1;
    while (ready_prefix < TABLE_DEPTH && shadow_set[ready_prefix]) ready_prefix++;
  endtask

  task automatic lookup(input logic [stbl_pkg::KEY_W-1:0] key);
    logic [31:0] junk;
    junk = $urandom;
    send_item(stbl_pkg::OP_LOOKUP, junk[stbl_pkg::IDX_W-1:0], $urandom, $urandom, key);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_entry_count(input logic [stbl_pkg::CNT_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [stbl_pkg::KEY_W-1:0] pick_key(input int unsigned span);
    logic [stbl_pkg::KEY_W-1:0] base;
    int unsigned                pick;
    pick = $urandom_range(0, 9);
    base = (span > 0) ? {32'h0, shadow_addr[$urandom_range(0, span - 1)]} : {32'h0, $urandom};
    case (pick)
      0, 1, 2, 3, 4: return base;
      5:             return base + 64'd1;
      6:             return base - 64'd1;
      7:             return {32'h0, $urandom};
      8:             return {$urandom, $urandom};
      default:       return {($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h1), base[31:0]};
    endcase
  endfunction

  task automatic run_phase(input int unsigned cnt);
    int unsigned                span;
    int unsigned                stride;
    int unsigned                idx;
    int unsigned                sel;
    logic [stbl_pkg::KEY_W-1:0] acc;
    settle();
    hush <= ($urandom_range(0, 3) == 0);
    calm <= (items_sent >= CALM_AFTER);
    write_entry_count(cnt[stbl_pkg::CNT_W-1:0]);
    span = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
    if (span <= 64 || span > ready_prefix) begin
      stride = $urandom_range(0, 1) ? $urandom_range(0, 3) : 32'hFFFF_FFFF / (span + 1);
      acc = $urandom_range(0, 1) ? 64'd0 : 64'($urandom_range(0, 32'h000F_FFFF));
      for (int unsigned i = 0; i < span; i++) begin
        load_entry(i, (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0], $urandom);
        acc += $urandom_range(0, stride);
      end
    end
    repeat ($urandom_range(20, 40)) begin
      sel = $urandom_range(0, 9);
      if (sel == 0 && span > 0) begin
        idx = $urandom_range(0, span - 1);
        load_entry(idx, shadow_addr[idx], $urandom);
      end else if (sel == 1) begin
        load_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom, $urandom);
      end else begin
        lookup(pick_key(span));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    lookup(64'd0);
    lookup({stbl_pkg::KEY_W{1'b1}});
    load_entry(0, 32'h0, 32'hFFFF_FFFF);
    load_entry(1, 32'd5, 32'd1);
    load_entry(2, 32'd5, 32'd2);
    load_entry(3, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
    load_entry(TABLE_DEPTH - 1, 32'hFFFF_FFFF, 32'h8000_0001);
    settle();
    write_entry_count(11'd4);
    lookup(64'd0);
    lookup(64'd5);
    lookup(64'd4);
    lookup(64'd6);
    lookup(64'hFFFF_FFFF);
    lookup(64'h1_0000_0005);
    lookup(64'h1_0000_0000);
    lookup({stbl_pkg::KEY_W{1'b1}});
    load_entry(1, 32'd100, 32'd3);
    lookup(64'd5);
    lookup(64'd100);
    settle();
    write_entry_count(11'd2);
    lookup(64'd100);
    lookup(64'd0);

    for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
      case (ph)
        3:       run_phase(TABLE_DEPTH);
        4:       run_phase(2047);
        5:       run_phase(0);
        6:       run_phase(1);
        default: run_phase((ready_prefix == TABLE_DEPTH && $urandom_range(0, 3) == 0) ?
                           $urandom_range(1000, 2047) : $urandom_range(2, 24));
      endcase
    end
    settle();

    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/stbl_pkg.sv
hw/rtl/sorted_table_binary_lookup_unit.sv
dv/sorted_table_binary_lookup_unit_checker.sv
dv/sorted_table_binary_lookup_unit_tb.sv
